// ===== hdl/etf_pkg.sv =====
package etf_pkg;

   // Payload bytes ahead of the check byte in one telemetry frame.
   localparam int unsigned PayloadLen = 9;
   localparam int unsigned CountWidth = 4;
   localparam logic [CountWidth-1:0] LastCount = CountWidth'(PayloadLen);

   // CRC-8, polynomial x^8 + x^2 + x + 1, MSB first, no reflection, no final XOR.
   localparam logic [7:0] CrcPoly = 8'h07;
   localparam logic [7:0] CrcInit = 8'h00;

   // One received byte together with its restart flag.
   typedef struct packed {
      logic       restart;
      logic [7:0] rx_byte;
   } rx_item_type;

   // One decoded frame.
   typedef struct packed {
      logic        frame_ok;
      logic [15:0] erpm_hundreds;
      logic [15:0] consumption;
      logic [15:0] current;
      logic [15:0] voltage;
      logic [7:0]  temperature;
   } telem_type;

   // Advance the CRC register by one data byte; eight shifts of an 8-bit value.
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CrcPoly;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

// ===== hdl/etf_input_stage.sv =====
module etf_input_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  etf_pkg::rx_item_type in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output etf_pkg::rx_item_type out_item
);
   import etf_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   rx_item_type item_ff;

   // The register may take a new byte whenever it is empty or is being emptied.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== hdl/etf_frame_engine.sv =====
module etf_frame_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_ready,
   input  etf_pkg::rx_item_type item,
   output logic                 result_valid,
   input  logic                 result_ready,
   output etf_pkg::telem_type   result
);
   import etf_pkg::*;

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic [7:0]            crc_ff;
   logic [7:0]            crc_in;
   logic [7:0]            store_ff [PayloadLen];
   logic                  result_valid_ff;
   logic                  result_valid_in;
   telem_type             result_ff;
   telem_type             result_in;

   logic [CountWidth-1:0] count_eff;
   logic [7:0]            crc_eff;
   logic                  take;
   logic                  at_check;
   logic                  crc_match;

   // The byte moves on only when the result register has room for what it may produce.
   assign item_ready = !result_valid_ff || result_ready;
   assign take       = item_valid && item_ready;

   // A restart makes this byte the first of a new frame.
   assign count_eff = item.restart ? '0 : count_ff;
   assign crc_eff   = item.restart ? CrcInit : crc_ff;
   assign at_check  = (count_eff >= LastCount);
   assign crc_match = (crc_eff == item.rx_byte);

   always_comb begin
      count_in = count_ff;
      crc_in   = crc_ff;
      if (take) begin
         if (at_check) begin
            count_in = '0;
            crc_in   = CrcInit;
         end else begin
            count_in = count_eff + CountWidth'(1);
            crc_in   = crc8_step(crc_eff, item.rx_byte);
         end
      end
   end

   always_comb begin
      result_in = '0;
      result_in.frame_ok = crc_match;
      if (crc_match) begin
         result_in.temperature   = store_ff[0];
         result_in.voltage       = {store_ff[1], store_ff[2]};
         result_in.current       = {store_ff[3], store_ff[4]};
         result_in.consumption   = {store_ff[5], store_ff[6]};
         result_in.erpm_hundreds = {store_ff[7], store_ff[8]};
      end
   end

   assign result_valid_in = (take && at_check) || (result_valid_ff && !result_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         crc_ff          <= CrcInit;
         result_valid_ff <= 1'b0;
      end else begin
         count_ff        <= count_in;
         crc_ff          <= crc_in;
         result_valid_ff <= result_valid_in;
      end
      if (take && !at_check) begin
         store_ff[count_eff] <= item.rx_byte;
      end
      if (take && at_check) begin
         result_ff <= result_in;
      end
   end

   assign result_valid = result_valid_ff;
   assign result       = result_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LastCount)
      else $error("byte count beyond the check byte position");

   a_check_gives_result: assert property (@(posedge clock) disable iff (reset)
      take && at_check |=> result_valid_ff)
      else $error("check byte taken without a result");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      result_valid_ff && !result_ready |=> result_valid_ff && $stable(result_ff))
      else $error("waiting result lost or changed");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      result_valid_ff && !result_ff.frame_ok |->
         result_ff.temperature == 8'd0 && result_ff.voltage == 16'd0 &&
         result_ff.current == 16'd0 && result_ff.consumption == 16'd0 &&
         result_ff.erpm_hundreds == 16'd0)
      else $error("failed frame carries data");

endmodule

// ===== hdl/esc_telemetry_frame_receiver.sv =====
// Channel   Direction  tdata (lowest bit up)                               tuser
// req_      in         rx_byte[7:0]                                        restart
// rsp_      out        temperature, voltage, current, consumption, erpm    frame_ok
//
// One byte is taken per cycle while the result side does not hold; once the tenth byte
// is taken, a result leaves through the input register and then the result register.
// The rate is set by the combinational CRC-8 update between those two registers.
// Reset is synchronous and active high; it clears the byte count, the CRC and both valids.
// When rsp_tready is low the result register holds, and one more byte waits in the input
// register before req_tready falls.

module esc_telemetry_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   input  logic [0:0]  req_tuser,   // restart[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // temperature[7:0], voltage[23:8], current[39:24],
                                    // consumption[55:40], erpm_hundreds[71:56]
   output logic [0:0]  rsp_tuser    // frame_ok[0]
);
   import etf_pkg::*;

   rx_item_type in_item;
   rx_item_type stage_item;
   logic        stage_valid;
   logic        stage_ready;
   telem_type   result;

   assign in_item.rx_byte = req_tdata;
   assign in_item.restart = req_tuser[0];

   // The input register holds one byte while the frame logic waits on the result side, so
   // the request side only stalls once that register is occupied as well.
   etf_input_stage u_input_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (in_item),
      .out_valid (stage_valid),
      .out_ready (stage_ready),
      .out_item  (stage_item)
   );

   // The frame engine keeps the byte count, the running CRC and the nine payload bytes,
   // and on the check byte loads its result register with the decoded frame.
   etf_frame_engine u_frame_engine (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (stage_valid),
      .item_ready   (stage_ready),
      .item         (stage_item),
      .result_valid (rsp_tvalid),
      .result_ready (rsp_tready),
      .result       (result)
   );

   // Result fields packed lowest first; a failed check leaves every data field at zero.
   assign rsp_tdata = {result.erpm_hundreds, result.consumption, result.current,
                       result.voltage, result.temperature};
   assign rsp_tuser = result.frame_ok;

endmodule
